### src/jsu_pkg.sv
package jsu_pkg;

  typedef enum logic [1:0] {
    MODE_AWAIT = 2'd0,
    MODE_BODY  = 2'd1,
    MODE_ESC   = 2'd2,
    MODE_HEX   = 2'd3
  } mode_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       string_done;
    logic       last_of_run;
  } res_t;

  localparam logic [7:0]  CH_QUOTE = 8'h22;
  localparam logic [7:0]  CH_BSLASH = 8'h5C;
  localparam logic [7:0]  CH_U = 8'h75;
  localparam logic [7:0]  CH_N = 8'h6E;
  localparam logic [7:0]  CH_T = 8'h74;
  localparam logic [7:0]  CH_R = 8'h72;
  localparam logic [7:0]  CH_B = 8'h62;
  localparam logic [7:0]  CH_F = 8'h66;
  localparam logic [7:0]  CTL_LF = 8'h0A;
  localparam logic [7:0]  CTL_TAB = 8'h09;
  localparam logic [7:0]  CTL_CR = 8'h0D;
  localparam logic [7:0]  CTL_BS = 8'h08;
  localparam logic [7:0]  CTL_FF = 8'h0C;

  localparam logic [15:0] UTF8_LIM1 = 16'h0080;
  localparam logic [15:0] UTF8_LIM2 = 16'h0800;
  localparam logic [7:0]  UTF8_LEAD2 = 8'hC0;
  localparam logic [7:0]  UTF8_LEAD3 = 8'hE0;
  localparam logic [7:0]  UTF8_CONT = 8'h80;
  localparam logic [7:0]  UTF8_MASK6 = 8'h3F;

  // Non-hex characters count as zero
  function automatic logic [3:0] hex_value(input logic [7:0] h);
    logic [3:0] v;
    v = 4'd0;
    if (h >= 8'h30 && h <= 8'h39) v = 4'(h - 8'h30);
    else if (h >= 8'h61 && h <= 8'h66) v = 4'(h - 8'h61 + 8'd10);
    else if (h >= 8'h41 && h <= 8'h46) v = 4'(h - 8'h41 + 8'd10);
    return v;
  endfunction

endpackage

### src/json_string_unescaper.sv
// Streaming unescaper for one quoted JSON string at a time. Each input item is one raw
// byte; the first byte of a string is taken as its opening quote whatever its value,
// and a closing quote or an item with in_tlast set ends the string. Escapes give their
// control bytes, \u takes up to four hex digits and gives 1 to 3 UTF-8 bytes. Each
// input item gives 0 to 3 output items; out_tlast marks the last one caused by that
// byte, out_tuser[1] marks the end of the string. A byte is decoded combinationally
// from an input register into a three-entry result buffer. With out_tready high, a
// byte that yields at most one output item streams at one item per clock; a \u escape
// giving more holds input until only its last byte is left; items drain one per cycle.
module json_string_unescaper
  import jsu_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_tdata,   // [7:0] in_byte
  input  logic       in_tlast,   // is_final
  output logic       out_tvalid,
  input  logic       out_tready,
  output logic [7:0] out_tdata,  // [7:0] out_byte
  output logic [1:0] out_tuser,  // [0] byte_valid, [1] string_done
  output logic       out_tlast   // last_of_run
);

  mode_t       mode_r, mode_nxt;
  logic [1:0]  seen_r, seen_nxt;
  logic [15:0] acc_r, acc_nxt;

  logic        in_full_r, in_full_nxt;
  logic [7:0]  in_byte_r;
  logic        in_fin_r;

  res_t        res_r [3];
  res_t        res_nxt [3];
  logic [1:0]  cnt_r, cnt_nxt;

  logic        pop, take, in_acc;

  assign pop    = out_tvalid && out_tready;
  assign take   = in_full_r && ((cnt_r == 2'd0) || (cnt_r == 2'd1 && pop));
  assign in_tready = !in_full_r || take;
  assign in_acc = in_tvalid && in_tready;

  assign out_tvalid = (cnt_r != 2'd0);
  assign out_tdata  = res_r[0].out_byte;
  assign out_tuser  = {res_r[0].string_done, res_r[0].byte_valid};
  assign out_tlast  = res_r[0].last_of_run;

  // Decode of the registered byte
  logic [7:0]  dbyte [3];
  logic [1:0]  dn;
  logic        done;
  mode_t       dmode;
  logic [1:0]  dseen;
  logic [15:0] dacc;
  logic [15:0] cp;
  logic        emit_cp;
  logic [7:0]  esc_v;
  logic [1:0]  nres;

  always_comb begin
    dbyte[0] = 8'h00;
    dbyte[1] = 8'h00;
    dbyte[2] = 8'h00;
    dn       = 2'd0;
    done     = 1'b0;
    dmode    = mode_r;
    dseen    = seen_r;
    dacc     = acc_r;
    cp       = 16'h0000;
    emit_cp  = 1'b0;
    esc_v    = in_byte_r;

    unique case (mode_r)
      MODE_AWAIT: begin
        dmode = MODE_BODY;
        done  = in_fin_r;
      end
      MODE_BODY: begin
        if (in_byte_r == CH_QUOTE) begin
          done = 1'b1;
        end else if (in_byte_r == CH_BSLASH && !in_fin_r) begin
          dmode = MODE_ESC;
        end else begin
          dbyte[0] = in_byte_r;
          dn       = 2'd1;
          done     = in_fin_r;
        end
      end
      MODE_ESC: begin
        dmode = MODE_BODY;
        if (in_byte_r == CH_U) begin
          dacc  = 16'h0000;
          dseen = 2'd0;
          if (in_fin_r) begin
            emit_cp = 1'b1;
            done    = 1'b1;
          end else begin
            dmode = MODE_HEX;
          end
        end else begin
          case (in_byte_r)
            CH_N:    esc_v = CTL_LF;
            CH_T:    esc_v = CTL_TAB;
            CH_R:    esc_v = CTL_CR;
            CH_B:    esc_v = CTL_BS;
            CH_F:    esc_v = CTL_FF;
            default: esc_v = in_byte_r;
          endcase
          dbyte[0] = esc_v;
          dn       = 2'd1;
          done     = in_fin_r;
        end
      end
      MODE_HEX: begin
        cp = {acc_r[11:0], hex_value(in_byte_r)};
        if (seen_r == 2'd3 || in_fin_r) begin
          emit_cp = 1'b1;
          dseen   = 2'd0;
          dacc    = 16'h0000;
          dmode   = MODE_BODY;
          done    = in_fin_r;
        end else begin
          dacc  = cp;
          dseen = seen_r + 2'd1;
        end
      end
      default: dmode = MODE_AWAIT;
    endcase

    if (emit_cp) begin
      if (cp < UTF8_LIM1) begin
        dbyte[0] = cp[7:0];
        dn       = 2'd1;
      end else if (cp < UTF8_LIM2) begin
        dbyte[0] = UTF8_LEAD2 | {3'b000, cp[10:6]};
        dbyte[1] = UTF8_CONT | (cp[7:0] & UTF8_MASK6);
        dn       = 2'd2;
      end else begin
        dbyte[0] = UTF8_LEAD3 | {4'b0000, cp[15:12]};
        dbyte[1] = UTF8_CONT | (cp[13:6] & UTF8_MASK6);
        dbyte[2] = UTF8_CONT | (cp[7:0] & UTF8_MASK6);
        dn       = 2'd3;
      end
    end

    if (done) begin
      dmode = MODE_AWAIT;
      dseen = 2'd0;
      dacc  = 16'h0000;
    end
  end

  // Build the result buffer for this byte, or drain the current one
  always_comb begin
    nres = (done && dn == 2'd0) ? 2'd1 : dn;
    mode_nxt = mode_r;
    seen_nxt = seen_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    for (int i = 0; i < 3; i++) res_nxt[i] = res_r[i];

    if (take) begin
      mode_nxt = dmode;
      seen_nxt = dseen;
      acc_nxt  = dacc;
      cnt_nxt  = nres;
      for (int i = 0; i < 3; i++) begin
        res_nxt[i].out_byte    = dbyte[i];
        res_nxt[i].byte_valid  = (2'(i) < dn);
        res_nxt[i].string_done = done && (2'(i) == nres - 2'd1);
        res_nxt[i].last_of_run = (2'(i) == nres - 2'd1);
      end
    end else if (pop) begin
      cnt_nxt    = cnt_r - 2'd1;
      res_nxt[0] = res_r[1];
      res_nxt[1] = res_r[2];
    end

    in_full_nxt = in_full_r;
    if (in_acc) in_full_nxt = 1'b1;
    else if (take) in_full_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r    <= MODE_AWAIT;
      seen_r    <= 2'd0;
      acc_r     <= 16'h0000;
      cnt_r     <= 2'd0;
      in_full_r <= 1'b0;
    end else begin
      mode_r    <= mode_nxt;
      seen_r    <= seen_nxt;
      acc_r     <= acc_nxt;
      cnt_r     <= cnt_nxt;
      in_full_r <= in_full_nxt;
    end
  end

  // Payload holds without reset
  always_ff @(posedge clk) begin
    if (in_acc) begin
      in_byte_r <= in_tdata;
      in_fin_r  <= in_tlast;
    end
    for (int i = 0; i < 3; i++) res_r[i] <= res_nxt[i];
  end

endmodule

### verif/tb_json_string_unescaper.sv
`timescale 1ns / 1ps

module tb_json_string_unescaper;
  import jsu_pkg::*;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       in_tvalid = 1'b0;
  logic       in_tready;
  logic [7:0] in_tdata = 8'h00;   // [7:0] in_byte
  logic       in_tlast = 1'b0;    // is_final
  logic       out_tvalid;
  logic       out_tready = 1'b0;
  logic [7:0] out_tdata;          // [7:0] out_byte
  logic [1:0] out_tuser;          // [0] byte_valid, [1] string_done
  logic       out_tlast;          // last_of_run

  // Decoder state mirrored from the block
  mode_t       dec_mode = MODE_AWAIT;
  logic [1:0]  hex_count = 2'd0;
  logic [15:0] code_point = 16'h0000;

  res_t pending_decoded[$];
  res_t want;
  int   errors = 0;

  bit idle_on = 1'b1;
  int rx_hold_req = 0;
  int rx_hold_left = 0;
  int rx_stall_left = 0;

  json_string_unescaper DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser),
    .out_tlast (out_tlast)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Work out the decoded bytes one raw byte produces and queue them
  task automatic predict_unescape(input logic [7:0] b, input logic fin);
    logic [7:0] dec[$];
    logic       ends;
    logic [7:0] v;
    logic [3:0] nib;
    res_t       r;
    ends = 1'b0;
    case (dec_mode)
      MODE_AWAIT: begin
        dec_mode = MODE_BODY;
        ends = fin;
      end
      MODE_BODY: begin
        if (b == CH_QUOTE) ends = 1'b1;
        else if (b == CH_BSLASH && !fin) dec_mode = MODE_ESC;
        else begin
          dec = {dec, b};
          ends = fin;
        end
      end
      MODE_ESC: begin
        dec_mode = MODE_BODY;
        if (b == CH_U && fin) begin
          // \u with no digits left gives U+0000
          dec = {dec, 8'h00};
          ends = 1'b1;
        end else if (b == CH_U) begin
          code_point = 16'h0000;
          hex_count = 2'd0;
          dec_mode = MODE_HEX;
        end else begin
          case (b)
            CH_N:    v = CTL_LF;
            CH_T:    v = CTL_TAB;
            CH_R:    v = CTL_CR;
            CH_B:    v = CTL_BS;
            CH_F:    v = CTL_FF;
            default: v = b;
          endcase
          dec = {dec, v};
          ends = fin;
        end
      end
      default: begin
        if (b >= "0" && b <= "9") nib = b[3:0];
        else if ((b >= "a" && b <= "f") || (b >= "A" && b <= "F")) nib = b[3:0] + 4'd9;
        else nib = 4'd0;
        code_point = {code_point[11:0], nib};
        if (hex_count == 2'd3 || fin) begin
          if (code_point < UTF8_LIM1) begin
            dec = {dec, code_point[7:0]};
          end else if (code_point < UTF8_LIM2) begin
            dec = {dec, UTF8_LEAD2 | {3'b000, code_point[10:6]}};
            dec = {dec, UTF8_CONT | {2'b00, code_point[5:0]}};
          end else begin
            dec = {dec, UTF8_LEAD3 | {4'h0, code_point[15:12]}};
            dec = {dec, UTF8_CONT | {2'b00, code_point[11:6]}};
            dec = {dec, UTF8_CONT | {2'b00, code_point[5:0]}};
          end
          hex_count = 2'd0;
          code_point = 16'h0000;
          dec_mode = MODE_BODY;
          ends = fin;
        end else begin
          hex_count = hex_count + 2'd1;
        end
      end
    endcase
    if (ends) begin
      dec_mode = MODE_AWAIT;
      hex_count = 2'd0;
      code_point = 16'h0000;
    end
    foreach (dec[i]) begin
      r.out_byte = dec[i];
      r.byte_valid = 1'b1;
      r.last_of_run = (i == dec.size() - 1);
      r.string_done = ends && r.last_of_run;
      pending_decoded = {pending_decoded, r};
    end
    if (ends && dec.size() == 0) begin
      r = '{8'h00, 1'b0, 1'b1, 1'b1};
      pending_decoded = {pending_decoded, r};
    end
  endtask

  // Offer one byte, hold until taken, then maybe idle
  task automatic send_byte(input logic [7:0] b, input logic fin);
    int gap;
    in_tdata <= b;
    in_tlast <= fin;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (in_tready !== 1'b1);
    predict_unescape(b, fin);
    @(negedge clk);
    gap = idle_on ? idle_len() : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic wait_drained();
    int n;
    in_tvalid <= 1'b0;
    n = 0;
    while (pending_decoded.size() != 0 && n < 20000) begin
      @(negedge clk);
      n++;
    end
    repeat (8) @(negedge clk);
  endtask

  task automatic test_escapes();
    logic [7:0] letters[6];
    letters = '{CH_N, CH_T, CH_R, CH_B, CH_F, CH_QUOTE};
    send_byte(8'hFF, 1'b0);  // any byte opens a string
    send_byte(8'h00, 1'b0);
    foreach (letters[i]) begin
      send_byte(CH_BSLASH, 1'b0);
      send_byte(letters[i], 1'b0);
    end
    send_byte(CH_QUOTE, 1'b0);
  endtask

  task automatic test_unicode_escapes();
    send_byte(CH_QUOTE, 1'b0);
    // mixed case digits, quote counted as zero digit
    send_byte(CH_BSLASH, 1'b0);
    send_byte(CH_U, 1'b0);
    send_byte("F", 1'b0);
    send_byte("f", 1'b0);
    send_byte(CH_QUOTE, 1'b0);
    send_byte("a", 1'b0);
    // short escape cut off by end of buffer
    send_byte(CH_BSLASH, 1'b0);
    send_byte(CH_U, 1'b0);
    send_byte("4", 1'b0);
    send_byte("1", 1'b1);
  endtask

  task automatic test_final_bytes();
    send_byte("Q", 1'b1);
    send_byte(CH_QUOTE, 1'b0);
    send_byte(CH_BSLASH, 1'b1);
    send_byte(CH_QUOTE, 1'b0);
    send_byte(CH_BSLASH, 1'b0);
    send_byte(CH_U, 1'b1);
  endtask

  task automatic test_output_stall();
    idle_on = 1'b0;
    rx_hold_req = 300;
    send_byte(CH_QUOTE, 1'b0);
    repeat (6) begin
      send_byte(CH_BSLASH, 1'b0);
      send_byte(CH_U, 1'b0);
      send_byte("F", 1'b0);
      send_byte("0", 1'b0);
      send_byte("0", 1'b0);
      send_byte("d", 1'b0);
      send_byte("z", 1'b0);
    end
    send_byte(CH_QUOTE, 1'b0);
    idle_on = 1'b1;
  endtask

  task automatic test_random_strings(input int n_items);
    logic [7:0] sb[$];
    bit         sf[$];
    logic [7:0] b;
    int         sent;
    int         kind;
    int         p;
    bit         low_cp;
    sent = 0;
    while (sent < n_items) begin
      sb.delete();
      sf.delete();
      idle_on = ($urandom_range(0, 3) != 0);
      if ($urandom_range(0, 19) == 0) begin
        // raw noise, final flag at random
        repeat ($urandom_range(1, 6)) begin
          sb = {sb, 8'($urandom_range(0, 255))};
          sf = {sf, bit'($urandom_range(0, 3) == 0)};
        end
      end else begin
        sb = {sb, ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255)) : CH_QUOTE};
        repeat ($urandom_range(0, 10)) begin
          kind = $urandom_range(0, 99);
          if (kind < 55) begin
            if ($urandom_range(0, 7) == 0) b = 8'($urandom_range(0, 255));
            else begin
              b = 8'($urandom_range(8'h20, 8'h7E));
              if (b == CH_QUOTE || b == CH_BSLASH) b = "x";
            end
            sb = {sb, b};
          end else if (kind < 80) begin
            sb = {sb, CH_BSLASH};
            case ($urandom_range(0, 8))
              0:       b = CH_N;
              1:       b = CH_T;
              2:       b = CH_R;
              3:       b = CH_B;
              4:       b = CH_F;
              5:       b = CH_QUOTE;
              6:       b = CH_BSLASH;
              7:       b = "/";
              default: b = 8'($urandom_range(0, 255));
            endcase
            sb = {sb, b};
          end else begin
            sb = {sb, CH_BSLASH};
            sb = {sb, CH_U};
            // lead with zeros now and then to reach the one and two byte forms
            low_cp = ($urandom_range(0, 2) == 0);
            for (int i = 0; i < 4; i++) begin
              if (low_cp && i < 2) b = "0";
              else begin
                case ($urandom_range(0, 9))
                  0, 1, 2, 3, 8: b = 8'("0" + $urandom_range(0, 9));
                  4, 5:          b = 8'("a" + $urandom_range(0, 5));
                  6, 7:          b = 8'("A" + $urandom_range(0, 5));
                  default:       b = 8'($urandom_range(0, 255));
                endcase
              end
              sb = {sb, b};
            end
          end
        end
        sb = {sb, CH_QUOTE};
        foreach (sb[i]) sf = {sf, 1'b0};
        kind = $urandom_range(0, 9);
        if (kind == 7) begin
          sf[sf.size() - 1] = 1'b1;
        end else if (kind == 8) begin
          // cut the string short at a random byte
          p = $urandom_range(0, sb.size() - 1);
          sb = sb[0:p];
          sf = sf[0:p];
          sf[p] = 1'b1;
        end else if (kind == 9) begin
          p = $urandom_range(0, sb.size() - 1);
          sf[p] = 1'b1;
        end
      end
      foreach (sb[i]) send_byte(sb[i], sf[i]);
      sent += sb.size();
      if ($urandom_range(0, 7) == 0) wait_drained();
    end
    idle_on = 1'b1;
  endtask

  // Receiver: long hold on request, random stalls otherwise
  always @(negedge clk) begin
    if (rx_hold_req > 0) begin
      rx_hold_left = rx_hold_req;
      rx_hold_req = 0;
    end
    if (rx_hold_left > 0) begin
      rx_hold_left--;
      out_tready <= 1'b0;
    end else if (rx_stall_left > 0) begin
      rx_stall_left--;
      out_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 2) == 0) begin
      rx_stall_left = idle_len();
      if (rx_stall_left > 0) begin
        rx_stall_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= 1'b1;
      end
    end else begin
      out_tready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_decoded.size() == 0) begin
        errors++;
        $display("%0t: unexpected item: got byte=%02h valid=%b done=%b last=%b",
                 $time, out_tdata, out_tuser[0], out_tuser[1], out_tlast);
      end else begin
        want = pending_decoded.pop_front();
        if (out_tdata !== want.out_byte || out_tuser[0] !== want.byte_valid ||
            out_tuser[1] !== want.string_done || out_tlast !== want.last_of_run) begin
          errors++;
          $display("%0t: mismatch: expected byte=%02h valid=%b done=%b last=%b, got byte=%02h valid=%b done=%b last=%b",
                   $time, want.out_byte, want.byte_valid, want.string_done, want.last_of_run,
                   out_tdata, out_tuser[0], out_tuser[1], out_tlast);
        end
      end
    end
  end

  initial begin
    #4_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_escapes();
    wait_drained();
    test_unicode_escapes();
    wait_drained();
    test_final_bytes();
    wait_drained();
    test_output_stall();
    wait_drained();
    test_random_strings(250);
    wait_drained();
    if (pending_decoded.size() != 0) begin
      errors += pending_decoded.size();
      $display("%0t: %0d expected items never arrived", $time, pending_decoded.size());
    end
    if (errors == 0) $display("Test completed successfully");
    else $display("Test completed with failures");
    $finish;
  end

endmodule

### json_string_unescaper.f
src/jsu_pkg.sv
src/json_string_unescaper.sv
verif/tb_json_string_unescaper.sv
